@@ src/lpfd_pkg.sv @@
// Package: types and constants shared by the length-prefixed frame decoder.
package lpfd_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] Overhead = CountW'(8);
  localparam logic [CountW-1:0] MinPacket = CountW'(8 + 1);

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StCapacity = 3'd2,
    StLength   = 3'd3,
    StChecksum = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               is_status;
    logic [2:0]         status;
    logic signed [15:0] client_id;
    logic [15:0]        frame_len;
  } out_item_t;

  typedef struct packed {
    logic      has_result;
    out_item_t item;
  } core_result_t;

endpackage

@@ src/lpfd_in_stage.sv @@
// Input register stage of the frame decoder.
module lpfd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpfd_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output lpfd_pkg::in_item_t item_o
);
  import lpfd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/lpfd_core.sv @@
// Packet state, running checksum and status decision of the frame decoder.
module lpfd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  fire_i,
  input  lpfd_pkg::in_item_t     item_i,
  output lpfd_pkg::core_result_t result_o
);
  import lpfd_pkg::*;

  logic [15:0]       capacity_q;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [15:0]       header_length_q, header_length_d;
  logic [31:0]       running_sum_q, running_sum_d;
  logic [31:0]       received_sum_q, received_sum_d;
  logic [15:0]       id_shift_q, id_shift_d;

  logic [CountW-1:0] pos, hdr_end, cnt_nx, over_len;
  logic [15:0]       hdr_nx, id_nx;
  logic [31:0]       sum_nx, rcv_nx;
  logic              is_payload;
  status_e           st;
  logic [7:0]        b;

  assign b       = item_i.in_byte;
  assign pos     = byte_count_q;
  assign hdr_end = {1'b0, header_length_q} + CountW'(2);
  assign is_payload = (pos >= CountW'(2)) && (pos < hdr_end);

  always_comb begin
    hdr_nx = header_length_q;
    if (pos == '0) begin
      hdr_nx = {b, 8'h00};
    end else if (pos == CountW'(1)) begin
      hdr_nx = {header_length_q[15:8], b};
    end
  end

  assign sum_nx   = is_payload ? running_sum_q + {24'd0, b} : running_sum_q;
  assign rcv_nx   = {received_sum_q[23:0], id_shift_q[15:8]};
  assign id_nx    = {id_shift_q[7:0], b};
  assign cnt_nx   = (pos != CountMax) ? pos + CountW'(1) : pos;
  assign over_len = cnt_nx - Overhead;

  always_comb begin
    priority if (cnt_nx < MinPacket) begin
      st = StShort;
    end else if (cnt_nx == CountMax || over_len > {1'b0, capacity_q}) begin
      st = StCapacity;
    end else if (cnt_nx != {1'b0, hdr_nx} + Overhead) begin
      st = StLength;
    end else if (rcv_nx != sum_nx) begin
      st = StChecksum;
    end else begin
      st = StOk;
    end
  end

  always_comb begin
    result_o = '0;
    if (item_i.end_of_packet) begin
      result_o.has_result     = 1'b1;
      result_o.item.is_status = 1'b1;
      result_o.item.status    = st;
      result_o.item.client_id = id_nx;
      result_o.item.frame_len = hdr_nx;
    end else if (is_payload) begin
      result_o.has_result    = 1'b1;
      result_o.item.out_byte = b;
    end
  end

  always_comb begin
    byte_count_d    = byte_count_q;
    header_length_d = header_length_q;
    running_sum_d   = running_sum_q;
    received_sum_d  = received_sum_q;
    id_shift_d      = id_shift_q;
    if (fire_i) begin
      if (item_i.end_of_packet) begin
        byte_count_d    = '0;
        header_length_d = '0;
        running_sum_d   = '0;
        received_sum_d  = '0;
        id_shift_d      = '0;
      end else begin
        byte_count_d    = cnt_nx;
        header_length_d = hdr_nx;
        running_sum_d   = sum_nx;
        received_sum_d  = rcv_nx;
        id_shift_d      = id_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q      <= 16'hFFFF;
      byte_count_q    <= '0;
      header_length_q <= '0;
      running_sum_q   <= '0;
      received_sum_q  <= '0;
      id_shift_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      byte_count_q    <= byte_count_d;
      header_length_q <= header_length_d;
      running_sum_q   <= running_sum_d;
      received_sum_q  <= received_sum_d;
      id_shift_q      <= id_shift_d;
    end
  end

endmodule

@@ src/lpfd_out_stage.sv @@
// Result register stage of the frame decoder.
module lpfd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lpfd_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpfd_pkg::out_item_t out_item_o
);
  import lpfd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ src/length_prefixed_frame_decoder_top.sv @@
// Top level of the length-prefixed frame decoder with additive checksum.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------
//   in      | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | out_valid_o / out_stall_i | out_item_o (out_item_t)
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (payload_capacity)
//
// One byte per cycle sustained, unless out_stall_i holds back a waiting result.
// Latency is set by the input register and the result register around the core.
// Bytes that give no result leave the input register without waiting on the output.
// Reset clears packet state and sets payload_capacity to 65535.
// out_stall_i backs up into in_stall_o only when a result is waiting.
module length_prefixed_frame_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpfd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpfd_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import lpfd_pkg::*;

  logic         stg_valid, fire, out_ready;
  in_item_t     stg_item;
  core_result_t res;

  assign cfg_ready_o = 1'b1;
  assign fire = stg_valid && (!res.has_result || out_ready);

  lpfd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (fire),
    .valid_o    (stg_valid),
    .item_o     (stg_item)
  );

  lpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (stg_item),
    .result_o    (res)
  );

  lpfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res.has_result),
    .item_i      (res.item),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ src/lpfd_checker.sv @@
// Port-level checker for the frame decoder, bound to the top level.
module lpfd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lpfd_pkg::out_item_t out_item_o
);
  import lpfd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_status |->
      out_item_o.status == StOk && out_item_o.client_id == 16'sd0 &&
      out_item_o.frame_len == 16'd0)
    else $error("payload transaction carries status fields");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_status |->
      out_item_o.out_byte == 8'd0 &&
      (out_item_o.status == StOk || out_item_o.status == StShort ||
       out_item_o.status == StCapacity || out_item_o.status == StLength ||
       out_item_o.status == StChecksum))
    else $error("bad status transaction");

  // an empty result register never holds off the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind length_prefixed_frame_decoder_top lpfd_checker u_lpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ tb/testbench.sv @@
// Testbench for the length-prefixed frame decoder: directed, config, backpressure, random.
module testbench;
  import lpfd_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [15:0] cfg_data_i;

  length_prefixed_frame_decoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // decoder shadow state
  logic [CountW-1:0] frm_count;
  logic [15:0]       frm_len;
  logic [31:0]       pay_sum;
  logic [31:0]       rx_sum;
  logic [15:0]       id_sr;
  logic [15:0]       capacity;

  out_item_t   pending_results[$];
  int          errors;
  int          bytes_sent;
  int          results_seen;
  int          status_seen[5];
  bit          no_gaps;
  int          hold_len;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_frame();
    frm_count = '0;
    frm_len   = '0;
    pay_sum   = '0;
    rx_sum    = '0;
    id_sr     = '0;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    int unsigned       pos;
    bit                in_payload;
    logic [CountW-1:0] total;
    status_e           st;
    pos = frm_count;
    in_payload = (pos >= 2) && (pos < 2 + frm_len);
    if (pos == 0) frm_len = {it.in_byte, 8'h00};
    else if (pos == 1) frm_len[7:0] = it.in_byte;
    if (in_payload) pay_sum = pay_sum + 32'(it.in_byte);
    rx_sum = {rx_sum[23:0], id_sr[15:8]};
    id_sr  = {id_sr[7:0], it.in_byte};
    if (frm_count != CountMax) frm_count = frm_count + 1'b1;
    res = '0;
    if (!it.end_of_packet) begin
      if (!in_payload) return 1'b0;
      res.out_byte = it.in_byte;
      return 1'b1;
    end
    total = frm_count;
    if (total < MinPacket) st = StShort;
    else if (total == CountMax || total - Overhead > {1'b0, capacity}) st = StCapacity;
    else if (total != {1'b0, frm_len} + Overhead) st = StLength;
    else if (rx_sum != pay_sum) st = StChecksum;
    else st = StOk;
    res.is_status = 1'b1;
    res.status    = st;
    res.client_id = id_sr;
    res.frame_len = frm_len;
    clear_frame();
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_item_o.is_status && out_item_o.status < 5) status_seen[out_item_o.status]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_item_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_item_o.out_byte);
          errors++;
        end
        if (out_item_o.is_status !== want.is_status) begin
          $error("is_status: expected %0d, got %0d", want.is_status, out_item_o.is_status);
          errors++;
        end
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          errors++;
        end
        if (out_item_o.client_id !== want.client_id) begin
          $error("client_id: expected %0d, got %0d", want.client_id, out_item_o.client_id);
          errors++;
        end
        if (out_item_o.frame_len !== want.frame_len) begin
          $error("frame_len: expected %0d, got %0d", want.frame_len, out_item_o.frame_len);
          errors++;
        end
      end
    end
  end

  // receiver: random stall per transaction, long hold on request
  initial begin
    int k;
    out_stall_i = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        k = hold_len;
        hold_len = 0;
      end else if (no_gaps) begin
        k = 0;
      end else begin
        k = $urandom_range(0, 3);
      end
      if (k > 0) begin
        out_stall_i = 1'b1;
        repeat (k) @(negedge clk);
        out_stall_i = 1'b0;
      end
      do @(posedge clk); while (!out_valid_o);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit eop);
    int unsigned gap;
    in_item_t    it;
    out_item_t   res;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.in_byte = b;
    it.end_of_packet = eop;
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk); while (in_stall_o);
    if (decode_byte(it, res)) pending_results.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // sender pause until every expected transaction is out
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    drain();
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    capacity = v;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void build_frame(ref logic [7:0] q[$], input logic [15:0] hdr,
                                      ref logic [7:0] pay[$], input logic [31:0] flip,
                                      input logic [15:0] id);
    logic [31:0] s;
    s = '0;
    q = {};
    q.push_back(hdr[15:8]);
    q.push_back(hdr[7:0]);
    foreach (pay[i]) begin
      q.push_back(pay[i]);
      s = s + 32'(pay[i]);
    end
    s = s ^ flip;
    q.push_back(s[31:24]);
    q.push_back(s[23:16]);
    q.push_back(s[15:8]);
    q.push_back(s[7:0]);
    q.push_back(id[15:8]);
    q.push_back(id[7:0]);
  endfunction

  function automatic void fill_random(ref logic [7:0] q[$], input int n);
    q = {};
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_directed();
    logic [7:0] pay[$];
    logic [7:0] q[$];
    pay = {8'hFF};
    build_frame(q, 16'd1, pay, 32'h0, 16'h8000);
    send_packet(q);
    pay = {8'h00};
    build_frame(q, 16'd1, pay, 32'hFFFF_FFFF, 16'h7FFF);
    send_packet(q);
    send_byte(8'hFF, 1'b1);
    pay = {8'h5A, 8'hA5};
    build_frame(q, 16'd1, pay, 32'h0, 16'h1234);
    send_packet(q);
    drain();
  endtask

  task automatic test_capacity();
    logic [7:0] pay[$];
    logic [7:0] q[$];
    write_capacity(16'd1);
    fill_random(pay, 2);
    build_frame(q, 16'd2, pay, 32'h0, 16'hFFFF);
    send_packet(q);
    fill_random(pay, 1);
    build_frame(q, 16'd1, pay, 32'h0, 16'h0000);
    send_packet(q);
    write_capacity(16'd0);
    build_frame(q, 16'd1, pay, 32'h0, 16'h00FF);
    send_packet(q);
    send_byte(8'h00, 1'b1);
    write_capacity(16'hFFFF);
    fill_random(pay, 2);
    build_frame(q, 16'd2, pay, 32'h0, 16'hABCD);
    send_packet(q);
    drain();
  endtask

  task automatic test_backpressure();
    logic [7:0] pay[$];
    logic [7:0] q[$];
    drain();
    no_gaps  = 1'b1;
    hold_len = 300;
    fill_random(pay, 120);
    build_frame(q, 16'd120, pay, 32'h0, 16'($urandom_range(0, 65535)));
    send_packet(q);
    drain();
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    logic [7:0]  pay[$];
    logic [7:0]  q[$];
    logic [15:0] caps[4];
    logic [15:0] id;
    int          target;
    int          kind;
    int          len;
    int          npay;
    caps[0] = 16'hFFFF;
    caps[1] = 16'($urandom_range(1, 16));
    caps[2] = 16'($urandom_range(16, 65535));
    caps[3] = 16'($urandom_range(4, 10));
    target = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(caps[ph]);
      target += 350;
      while (bytes_sent < target) begin
        no_gaps = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        npay = len;
        case ($urandom_range(0, 3))
          0: id = 16'h8000;
          1: id = 16'h7FFF;
          default: id = 16'($urandom_range(0, 65535));
        endcase
        if (kind >= 70 && kind < 80) begin
          npay = (len > 0 && $urandom_range(0, 1)) ? len - 1 : len + $urandom_range(1, 4);
        end
        if (kind >= 90) begin
          fill_random(q, $urandom_range(1, 12));
        end else begin
          fill_random(pay, npay);
          build_frame(q, 16'(len), pay,
                      (kind >= 60 && kind < 70) ? 32'h1 << $urandom_range(0, 31) : 32'h0, id);
          if (kind >= 80) q = q[0:$urandom_range(0, q.size() - 2)];
        end
        send_packet(q);
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    errors      = 0;
    bytes_sent  = 0;
    results_seen = 0;
    no_gaps     = 1'b0;
    hold_len    = 0;
    capacity    = 16'hFFFF;
    clear_frame();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_capacity();
    test_backpressure();
    test_random();

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes, checked %0d results across capacity settings and stalls.",
             bytes_sent, results_seen);
    $display("Status seen ok/short/capacity/length/checksum: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
